// File: rtl/c3s_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the 3x3 Cramer's-rule solver.
package c3s_pkg;

    localparam int DATA_W       = 32;              // one Q-format field
    localparam int N_IN_FIELDS  = 12;
    localparam int DET_W        = 3 * DATA_W + 2;  // exact triple-product sum
    localparam int QB           = DATA_W + 1;      // quotient bits kept
    localparam int THR_W        = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int APB_AW       = 2;
    localparam int APB_DW       = 32;

    localparam logic [THR_W-1:0]  THR_RST  = 16'd328;
    localparam logic [APB_AW-1:0] ADDR_THR = 2'd0;

    typedef logic [2:0][DATA_W-1:0] t_vec;
    typedef logic [3:0][DET_W-1:0]  t_dets;

    typedef struct packed {
        logic vld;
        logic sing;
    } t_ctl;

endpackage

// File: rtl/c3s_det.sv
`timescale 1ns / 1ps
// Determinant pipeline: cross products, split dot products, exact sums.
module c3s_det (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  logic           i_vld,
    input  c3s_pkg::t_vec  i_c1,
    input  c3s_pkg::t_vec  i_c2,
    input  c3s_pkg::t_vec  i_c3,
    input  c3s_pkg::t_vec  i_r,
    output logic           o_vld,
    output c3s_pkg::t_dets o_det
);
    import c3s_pkg::*;

    localparam int PW = 2 * DATA_W;
    localparam int CW = PW + 1;
    localparam int PH = CW + DATA_W;

    t_vec a_vec [3];
    t_vec b_vec [3];

    logic signed [PW-1:0]    n_pa [3][3];
    logic signed [PW-1:0]    n_pb [3][3];
    logic signed [PW-1:0]    r_pa [3][3];
    logic signed [PW-1:0]    r_pb [3][3];
    logic signed [CW-1:0]    r_cr [3][3];
    logic signed [PH-1:0]    n_ph [4][3];
    logic signed [PH-1:0]    n_pl [4][3];
    logic signed [PH-1:0]    r_ph [4][3];
    logic signed [PH-1:0]    r_pl [4][3];
    logic signed [DET_W-1:0] r_t  [4][3];
    logic signed [DET_W-1:0] r_det [4];
    t_vec r_c1_1, r_r_1, r_c1_2, r_r_2;
    logic [4:0] r_vld;

    // crosses: c2 x c3, c3 x c1, c1 x c2
    assign a_vec[0] = i_c2;
    assign b_vec[0] = i_c3;
    assign a_vec[1] = i_c3;
    assign b_vec[1] = i_c1;
    assign a_vec[2] = i_c1;
    assign b_vec[2] = i_c2;

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            for (int i = 0; i < 3; i++) begin
                n_pa[p][i] = signed'(a_vec[p][(i + 1) % 3]) * signed'(b_vec[p][(i + 2) % 3]);
                n_pb[p][i] = signed'(a_vec[p][(i + 2) % 3]) * signed'(b_vec[p][(i + 1) % 3]);
            end
        end
    end

    // D0 = c1.k0, D1 = r.k0, D2 = r.k1, D3 = r.k2
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 3; i++) begin
                if (j == 0) begin
                    n_ph[j][i] = signed'(r_cr[0][i][CW-1:DATA_W]) * signed'(r_c1_2[i]);
                    n_pl[j][i] = signed'({1'b0, r_cr[0][i][DATA_W-1:0]})
                                 * signed'(r_c1_2[i]);
                end else begin
                    n_ph[j][i] = signed'(r_cr[j-1][i][CW-1:DATA_W]) * signed'(r_r_2[i]);
                    n_pl[j][i] = signed'({1'b0, r_cr[j-1][i][DATA_W-1:0]})
                                 * signed'(r_r_2[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_c1_1 <= i_c1;
            r_r_1  <= i_r;
            r_c1_2 <= r_c1_1;
            r_r_2  <= r_r_1;
            for (int p = 0; p < 3; p++) begin
                for (int i = 0; i < 3; i++) begin
                    r_pa[p][i] <= n_pa[p][i];
                    r_pb[p][i] <= n_pb[p][i];
                    r_cr[p][i] <= CW'(r_pa[p][i]) - CW'(r_pb[p][i]);
                end
            end
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_ph[j][i] <= n_ph[j][i];
                    r_pl[j][i] <= n_pl[j][i];
                    r_t[j][i]  <= (DET_W'(r_ph[j][i]) <<< DATA_W) + DET_W'(r_pl[j][i]);
                end
                r_det[j] <= r_t[j][0] + r_t[j][1] + r_t[j][2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    assign o_vld = r_vld[4];
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            o_det[j] = r_det[j];
        end
    end

endmodule

// File: rtl/c3s_prep.sv
`timescale 1ns / 1ps
// Divider set-up: magnitudes, signs, singular test, rounded dividends, range check.
module c3s_prep #(
    parameter int FRAC_BITS = c3s_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_ce,
    input  logic                                  i_vld,
    input  c3s_pkg::t_dets                        i_det,
    input  logic [c3s_pkg::THR_W-1:0]             i_thr,
    output c3s_pkg::t_ctl                         o_ctl,
    output logic [c3s_pkg::DET_W+FRAC_BITS+c3s_pkg::QB+1:0] o_n2 [3],
    output logic [c3s_pkg::DET_W:0]               o_d2,
    output logic [2:0]                            o_neg,
    output logic [2:0]                            o_povf
);
    import c3s_pkg::*;

    localparam int NW = DET_W + FRAC_BITS + 2;
    localparam int RW = DET_W + FRAC_BITS + QB + 2;

    logic [DET_W-1:0] r_mag [4];
    logic [3:0]       r_sgn;
    logic             r_zero;
    logic [NW-1:0]    r_n2b [3];
    logic [DET_W:0]   r_d2b;
    logic [2:0]       r_qnb;
    logic             r_singb;
    logic [RW-1:0]    r_n2c [3];
    logic [DET_W:0]   r_d2c;
    logic [2:0]       r_qnc;
    logic [2:0]       r_povf;
    logic             r_singc;
    logic [2:0]       r_vld;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int j = 0; j < 4; j++) begin
                r_mag[j] <= i_det[j][DET_W-1] ? DET_W'(0) - i_det[j] : i_det[j];
                r_sgn[j] <= i_det[j][DET_W-1];
            end
            r_zero <= (i_det[0] == '0);

            for (int i = 0; i < 3; i++) begin
                r_n2b[i] <= (NW'(r_mag[i+1]) << (FRAC_BITS + 1)) + NW'(r_mag[0]);
                r_qnb[i] <= r_sgn[i+1] ^ r_sgn[0];
            end
            r_d2b   <= {r_mag[0], 1'b0};
            r_singb <= r_zero || (r_mag[0] < (DET_W'(i_thr) << (2 * FRAC_BITS)));

            for (int i = 0; i < 3; i++) begin
                r_n2c[i]  <= RW'(r_n2b[i]);
                r_povf[i] <= RW'(r_n2b[i]) >= (RW'(r_d2b) << QB);
            end
            r_d2c   <= r_d2b;
            r_qnc   <= r_qnb;
            r_singc <= r_singb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    assign o_ctl.vld  = r_vld[2];
    assign o_ctl.sing = r_singc;
    assign o_n2       = r_n2c;
    assign o_d2       = r_d2c;
    assign o_neg      = r_qnc;
    assign o_povf     = r_povf;

endmodule

// File: rtl/c3s_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider lane, one quotient bit per stage.
module c3s_div #(
    parameter int FRAC_BITS = c3s_pkg::FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_ce,
    input  logic [c3s_pkg::DET_W+FRAC_BITS+c3s_pkg::QB+1:0] i_n2,
    input  logic [c3s_pkg::DET_W:0]                       i_d2,
    input  logic                                          i_neg,
    input  logic                                          i_povf,
    output logic [c3s_pkg::QB-1:0]                        o_q,
    output logic                                          o_neg,
    output logic                                          o_povf
);
    import c3s_pkg::*;

    localparam int RW = DET_W + FRAC_BITS + QB + 2;

    logic [RW-1:0]  r_rem  [QB];
    logic [DET_W:0] r_d    [QB];
    logic [QB-1:0]  r_q    [QB];
    logic           r_neg  [QB];
    logic           r_povf [QB];

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [RW-1:0]  rem_in;
        logic [DET_W:0] d_in;
        logic [QB-1:0]  q_in;
        logic           neg_in;
        logic           povf_in;
        logic [RW-1:0]  dsh;
        logic           ge;

        if (s == 0) begin : g_first
            assign rem_in  = i_n2;
            assign d_in    = i_d2;
            assign q_in    = '0;
            assign neg_in  = i_neg;
            assign povf_in = i_povf;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign d_in    = r_d[s-1];
            assign q_in    = r_q[s-1];
            assign neg_in  = r_neg[s-1];
            assign povf_in = r_povf[s-1];
        end

        assign dsh = RW'(d_in) << (QB - 1 - s);
        assign ge  = (rem_in >= dsh);

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[s]  <= ge ? rem_in - dsh : rem_in;
                r_d[s]    <= d_in;
                r_q[s]    <= {q_in[QB-2:0], ge};
                r_neg[s]  <= neg_in;
                r_povf[s] <= povf_in;
            end
        end
    end

    assign o_q    = r_q[QB-1];
    assign o_neg  = r_neg[QB-1];
    assign o_povf = r_povf[QB-1];

endmodule

// File: rtl/cramer_3x3_solver.sv
`timescale 1ns / 1ps
// Top level of the 3x3 Cramer's-rule solver: APB register, stream ports, pipeline.
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid / tready           tdata: 12 x Q fields
//  m_axis    out  tvalid / tready           tdata: 3 unknowns, tuser: flags
//  apb       in   psel / penable / pready   singular_threshold at 0x0
//
//  One system per cycle while the output is not stalled; 5 determinant, 3 set-up,
//  33 divider stages and 1 output register, the divider giving one bit per stage.
//  Reset is synchronous; it clears all valid bits and loads the threshold.
//  When the output transfer stalls the whole pipe holds; nothing is lost or repeated.
module cramer_3x3_solver #(
    parameter int FRAC_BITS = c3s_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [c3s_pkg::APB_AW-1:0]    paddr,
    input  logic [c3s_pkg::APB_DW-1:0]    pwdata,
    output logic [c3s_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // col1_x col1_y col1_z col2_x col2_y col2_z col3_x col3_y col3_z rhs_x rhs_y rhs_z
    input  logic [c3s_pkg::N_IN_FIELDS*c3s_pkg::DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // unknown_1 unknown_2 unknown_3
    output logic [3*c3s_pkg::DATA_W-1:0]  m_axis_tdata,
    // singular overflow
    output logic [1:0]                    m_axis_tuser
);
    import c3s_pkg::*;

    localparam int RW = DET_W + FRAC_BITS + QB + 2;

    logic [THR_W-1:0] r_thr;
    logic             ce;
    t_vec             c1, c2, c3, rv;
    logic             det_vld;
    t_dets            det;
    t_ctl             pctl;
    logic [RW-1:0]    n2 [3];
    logic [DET_W:0]   d2;
    logic [2:0]       pneg, ppovf;
    logic [QB-1:0]    q [3];
    logic [2:0]       qneg, qpovf;
    logic [QB-1:0]    r_dv, r_ds;
    logic [QB-1:0]    lim [3];
    logic [2:0]       sat;
    logic [DATA_W-1:0] n_u [3];
    logic             r_out_vld;
    logic [DATA_W-1:0] r_u [3];
    logic             r_sing, r_ovf;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_THR) ? APB_DW'(r_thr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RST;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_THR) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    // global advance: stall only when the output register is full and held
    assign ce            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = ce;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c1[i] = s_axis_tdata[i*DATA_W +: DATA_W];
            c2[i] = s_axis_tdata[(3+i)*DATA_W +: DATA_W];
            c3[i] = s_axis_tdata[(6+i)*DATA_W +: DATA_W];
            rv[i] = s_axis_tdata[(9+i)*DATA_W +: DATA_W];
        end
    end

    c3s_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (s_axis_tvalid),
        .i_c1    (c1),
        .i_c2    (c2),
        .i_c3    (c3),
        .i_r     (rv),
        .o_vld   (det_vld),
        .o_det   (det)
    );

    c3s_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (det_vld),
        .i_det   (det),
        .i_thr   (r_thr),
        .o_ctl   (pctl),
        .o_n2    (n2),
        .o_d2    (d2),
        .o_neg   (pneg),
        .o_povf  (ppovf)
    );

    for (genvar k = 0; k < 3; k++) begin : g_lane
        c3s_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk  (i_clk),
            .i_ce   (ce),
            .i_n2   (n2[k]),
            .i_d2   (d2),
            .i_neg  (pneg[k]),
            .i_povf (ppovf[k]),
            .o_q    (q[k]),
            .o_neg  (qneg[k]),
            .o_povf (qpovf[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (ce) begin
            r_dv <= {r_dv[QB-2:0], pctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ds <= {r_ds[QB-2:0], pctl.sing};
        end
    end

    // saturate to the signed range and restore the sign
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lim[k] = qneg[k] ? (QB'(1) << (DATA_W - 1))
                             : (QB'(1) << (DATA_W - 1)) - QB'(1);
            sat[k] = qpovf[k] || (q[k] > lim[k]);
            n_u[k] = qneg[k] ? DATA_W'(QB'(0) - (sat[k] ? lim[k] : q[k]))
                             : DATA_W'(sat[k] ? lim[k] : q[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_out_vld <= r_dv[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                r_u[k] <= r_ds[QB-1] ? '0 : n_u[k];
            end
            r_sing <= r_ds[QB-1];
            r_ovf  <= !r_ds[QB-1] && (|sat);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_u[2], r_u[1], r_u[0]};
    assign m_axis_tuser  = {r_ovf, r_sing};

endmodule

// File: rtl/c3s_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the solver, bound to the top level.
module c3s_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("singular result not zero");

    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[31:0] == 32'h7FFFFFFF || m_axis_tdata[31:0] == 32'h80000000 ||
            m_axis_tdata[63:32] == 32'h7FFFFFFF || m_axis_tdata[63:32] == 32'h80000000 ||
            m_axis_tdata[95:64] == 32'h7FFFFFFF || m_axis_tdata[95:64] == 32'h80000000)
        else $error("overflow without a saturated unknown");

    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

endmodule

bind cramer_3x3_solver c3s_chk u_c3s_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: test/cramer_3x3_solver_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 Cramer's-rule solver.
module cramer_3x3_solver_tb;
    import c3s_pkg::*;

    typedef logic signed [DATA_W-1:0] t_fld;
    typedef t_fld t_system [N_IN_FIELDS];

    typedef struct {
        logic [DATA_W-1:0] unk [3];
        logic              sing;
        logic              ovf;
    } t_solution;

    class solution_board;
        logic [THR_W-1:0] thr;
        t_solution        pending [$];
        int unsigned      errors;
        int unsigned      n_sing;
        int unsigned      n_ovf;
        int unsigned      n_done;

        function new();
            thr = THR_RST;
        endfunction

        function automatic logic signed [127:0] triple(
            input logic signed [127:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
            return a1 * b2 * c0 - a2 * b1 * c0 + a2 * b0 * c1
                 - a0 * b2 * c1 + a0 * b1 * c2 - a1 * b0 * c2;
        endfunction

        function automatic logic [DATA_W-1:0] divide(input logic signed [127:0] num,
            input logic [127:0] dm, input logic dneg, inout logic ovf);
            logic [127:0] nm, n2, q, lim;
            logic         neg;
            neg = num[127] ^ dneg;
            nm  = num[127] ? -num : num;
            n2  = (nm << (FRAC_BITS_DEF + 1)) + dm;
            q   = n2 / (dm << 1);
            lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (q > lim) begin
                q   = lim;
                ovf = 1'b1;
            end
            return neg ? -q[DATA_W-1:0] : q[DATA_W-1:0];
        endfunction

        function void note(input t_system s);
            t_solution        e;
            logic signed [127:0] d0;
            logic [127:0]     dm;
            d0 = triple(s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7], s[8]);
            dm = d0[127] ? -d0 : d0;
            e.ovf = 1'b0;
            if (dm == 0 || dm < ({112'd0, thr} << (2 * FRAC_BITS_DEF))) begin
                e.unk  = '{default: '0};
                e.sing = 1'b1;
            end else begin
                e.sing   = 1'b0;
                e.unk[0] = divide(triple(s[9], s[10], s[11], s[3], s[4], s[5],
                                         s[6], s[7], s[8]), dm, d0[127], e.ovf);
                e.unk[1] = divide(triple(s[0], s[1], s[2], s[9], s[10], s[11],
                                         s[6], s[7], s[8]), dm, d0[127], e.ovf);
                e.unk[2] = divide(triple(s[0], s[1], s[2], s[3], s[4], s[5],
                                         s[9], s[10], s[11]), dm, d0[127], e.ovf);
            end
            pending.push_back(e);
        endfunction

        function void check(input logic [3*DATA_W-1:0] data, input logic [1:0] flags);
            t_solution e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, actual %h flags %b", $time, data, flags);
                errors++;
                return;
            end
            e = pending.pop_front();
            n_done++;
            n_sing += e.sing;
            n_ovf  += e.ovf;
            for (int k = 0; k < 3; k++)
                if (data[k*DATA_W +: DATA_W] !== e.unk[k]) begin
                    $display("%0t: unknown_%0d expected %h actual %h", $time, k + 1,
                             e.unk[k], data[k*DATA_W +: DATA_W]);
                    errors++;
                end
            if (flags[0] !== e.sing) begin
                $display("%0t: singular expected %b actual %b", $time, e.sing, flags[0]);
                errors++;
            end
            if (flags[1] !== e.ovf) begin
                $display("%0t: overflow expected %b actual %b", $time, e.ovf, flags[1]);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0]          paddr = '0;
    logic [APB_DW-1:0]          pwdata = '0;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    // col1_x col1_y col1_z col2_x col2_y col2_z col3_x col3_y col3_z rhs_x rhs_y rhs_z
    logic [N_IN_FIELDS*DATA_W-1:0] s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // unknown_1 unknown_2 unknown_3
    logic [3*DATA_W-1:0]        m_axis_tdata;
    // singular overflow
    logic [1:0]                 m_axis_tuser;

    solution_board sb = new();
    int unsigned   hold_cycles;
    logic          hold_req = 1'b0;
    logic          hold_done = 1'b0;
    logic          idle_on = 1'b1;
    int unsigned   n_items;

    cramer_3x3_solver i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random back-pressure plus one long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check(m_axis_tdata, m_axis_tuser);
        if (hold_req && !hold_done) begin
            hold_cycles = 400;
            hold_done   = 1'b1;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (pick_gap() == 0);
        end
    end

    task automatic send(input t_system s);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        for (int k = 0; k < N_IN_FIELDS; k++) s_axis_tdata[k*DATA_W +: DATA_W] <= s[k];
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note(s);
        n_items++;
    endtask

    task automatic set_threshold(input logic [APB_DW-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_THR;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.thr = v[THR_W-1:0];
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_fld small_q();
        return t_fld'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    function automatic t_system diag(input t_fld a, b, c, rx, ry, rz);
        t_system s;
        s = '{default: '0};
        s[0] = a; s[4] = b; s[8] = c;
        s[9] = rx; s[10] = ry; s[11] = rz;
        return s;
    endfunction

    function automatic t_system random_system();
        t_system     s;
        int unsigned kind;
        kind = $urandom_range(0, 99);
        for (int k = 0; k < N_IN_FIELDS; k++) begin
            if (kind < 50)      s[k] = small_q();
            else if (kind < 65) s[k] = $urandom;
            else if (kind < 75) s[k] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else if (kind < 90) s[k] = t_fld'(int'($urandom_range(0, 1024)) - 512);
            else                s[k] = small_q();
        end
        // dependent columns: third = first + second, near-singular when nudged
        if (kind >= 90) begin
            for (int k = 0; k < 3; k++) s[6+k] = s[k] + s[3+k];
            if ($urandom_range(0, 1)) s[8] = s[8] + t_fld'($urandom_range(0, 3));
        end
        if (kind >= 75 && kind < 90 && $urandom_range(0, 1)) s[0] = small_q();
        return s;
    endfunction

    initial begin
        t_system s;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default threshold: boundary, identity, extremes
        send(diag(32'd328, 32'h1_0000, 32'h1_0000, 32'h1_0000, -32'sh2_0000, 32'h7FFF_FFFF));
        send(diag(32'd327, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000));
        send(diag(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1));
        send(diag(32'h1_0000, 32'h1_0000, 32'h0_8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1_0000));
        send(diag(-32'sh1_0000, 32'h1_0000, 32'h1_0000, 32'h7FFF_FFFF, 32'h8000_0000, 3));
        s = '{default: 32'h8000_0000}; send(s);
        s = '{default: 32'h7FFF_FFFF}; send(s);
        s = '{default: 32'hFFFF_FFFF}; send(s);
        s = '{default: '0}; send(s);
        s = diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1, -1); send(s);
        s = diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 5, 7); send(s);
        drain();

        // zero threshold: exact-zero determinant and rounding ties
        set_threshold(32'd0);
        s = '{default: '0}; send(s);
        send(diag(32'h2_0000, 1, 1, 1, 1, 1));
        send(diag(32'h2_0000, 1, 1, -1, -1, 3));
        send(diag(32'h2_0000, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, -3));
        send(diag(1, 1, 1, 1, -1, 32'h7FFF_FFFF));
        send(diag(3, 1, 1, 1, 2, -2));
        s = diag(32'h1_0000, 32'h1_0000, 32'h1_0000, 1, 2, 3);
        s[6] = s[0]; s[7] = s[1]; s[8] = s[2]; send(s);
        repeat (200) send(random_system());
        drain();

        // largest threshold, upper bits of the write are dropped
        set_threshold(32'hABCD_FFFF);
        repeat (300) send(random_system());
        drain();

        set_threshold($urandom_range(1, 2000));
        idle_on = 1'b0;
        repeat (150) send(random_system());
        idle_on = 1'b1;
        hold_req = 1'b1;
        repeat (150) send(random_system());
        hold_req = 1'b0;
        drain();

        set_threshold(32'd328);
        repeat (500) send(random_system());
        drain();

        $display("Sent %0d systems over five threshold settings; %0d results checked,",
                 n_items, sb.n_done);
        $display("%0d flagged singular and %0d saturated.", sb.n_sing, sb.n_ovf);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
